### hdl/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`endif

### hdl/mds_pkg.sv
package mds_pkg;
  typedef struct packed {
    logic [1:0]         action;
    logic [2:0]         command_op;
    logic signed [31:0] command_value;
    logic [1:0]         tune_request_mode;
    logic [31:0]        now_ms;
    logic [15:0]        fault_bits;
    logic [5:0]         phase_flags;
    logic signed [31:0] forced_speed;
    logic signed [31:0] observer_confidence;
  } mds_in_t;

  typedef struct packed {
    logic [3:0]         current_state;
    logic [7:0]         action_bits;
    logic [16:0]        blend_factor;
    logic [15:0]        transition_retries;
    logic signed [31:0] speed_reference;
  } mds_out_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'd0, ST_INIT = 4'd1, ST_CAL = 4'd2, ST_IDENT = 4'd3,
    ST_ALIGN = 4'd4, ST_OLSTART = 4'd5, ST_OLRAMP = 4'd6, ST_TRANS = 4'd7,
    ST_RUN = 4'd8, ST_TUNE = 4'd9, ST_STOP = 4'd10, ST_FAULT = 4'd11
  } mode_t;

  typedef enum logic [1:0] {
    SEQ_IDLE, SEQ_DIV, SEQ_FIN, SEQ_OUT
  } seq_t;

  localparam logic [1:0] ACT_LATCH = 2'd0;
  localparam logic [1:0] ACT_FAST  = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  localparam logic [2:0] OP_RUN_SPEED  = 3'd1;
  localparam logic [2:0] OP_RUN_TORQUE = 3'd2;
  localparam logic [2:0] OP_IDENTIFY   = 3'd3;
  localparam logic [2:0] OP_TUNE       = 3'd4;
  localparam logic [2:0] OP_CLEAR      = 3'd5;
  localparam logic [2:0] OP_STOP       = 3'd6;

  localparam logic [2:0] CFG_ALIGN = 3'd0;
  localparam logic [2:0] CFG_OLTGT = 3'd1;
  localparam logic [2:0] CFG_MINCF = 3'd2;
  localparam logic [2:0] CFG_HOLD  = 3'd3;
  localparam logic [2:0] CFG_BLEND = 3'd4;

  localparam logic [31:0] INIT_WAIT_MS  = 32'd200;
  localparam logic [31:0] CAL_WAIT_MS   = 32'd500;
  localparam logic [31:0] IDENT_WAIT_MS = 32'd5000;
  localparam logic [31:0] RAMP_TIMEOUT  = 32'd2000;
  localparam logic [31:0] STOP_WAIT_MS  = 32'd500;
  localparam logic [16:0] Q16_ONE       = 17'h10000;

  function automatic logic [7:0] entry_actions(input mode_t s);
    logic [7:0] a;
    unique case (s)
      ST_IDENT:   a = 8'h23;
      ST_ALIGN:   a = 8'h07;
      ST_OLSTART: a = 8'h0F;
      ST_OLRAMP:  a = 8'h0F;
      ST_TRANS:   a = 8'h17;
      ST_RUN:     a = 8'h15;
      ST_TUNE:    a = 8'h55;
      ST_STOP:    a = 8'h15;
      ST_FAULT:   a = 8'h80;
      default:    a = 8'h00;
    endcase
    return a;
  endfunction
endpackage

### hdl/mds_divider.sv
module mds_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] num,
  input  logic [15:0] den,
  output logic        busy,
  output logic        done,
  output logic [16:0] quo
);
  // restoring divide of num*65536 by den, one quotient bit per cycle
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] dvd_r, dvd_nxt;
  logic [16:0] quo_r, quo_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [32:0] trial;

  always_comb begin
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    trial = {rem_r, dvd_r[31]} - {17'd0, den};
    if (start) begin
      rem_nxt = 32'd0;
      dvd_nxt = {num, 16'd0};
      quo_nxt = 17'd0;
      cnt_nxt = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[30:0], 1'b0};
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[15:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[30:0], dvd_r[31]};
        quo_nxt = {quo_r[15:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= 6'd0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
  end

  assign busy = busy_r;
  assign done = busy_r && (cnt_r == 6'd1);
  assign quo = quo_nxt;
endmodule

### hdl/motor_drive_supervisor_fsm.sv
// channel | direction | handshake
// in_     | input     | in_valid / in_stall
// out_    | output    | out_valid / out_stall
// cfg_    | input     | cfg_we, cfg_index, cfg_data
// a latch or fast transaction passes through SEQ_DIV to SEQ_OUT; a slow tick also passes SEQ_FIN,
// which waits there when the blend divides, the divide being a 32-step shift-subtract unit
// one transaction at a time: in_stall is high from acceptance until the result
// is taken; the result holds while out_stall is high
// synchronous active-low reset returns to idle with default registers
module motor_drive_supervisor_fsm (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mds_pkg::mds_in_t     in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mds_pkg::mds_out_t    out_data,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data
);
  import mds_pkg::*;

  logic [15:0] align_r, hold_ms_r, blend_ms_r;
  logic signed [31:0] oltgt_r, mincf_r;

  mode_t mode_r, mode_nxt;
  logic [31:0] entry_r, entry_nxt, bstart_r, bstart_nxt, hstart_r, hstart_nxt;
  logic [16:0] blend_r, blend_nxt;
  logic hstarted_r, hstarted_nxt, runq_r, runq_nxt, idq_r, idq_nxt, tuneq_r, tuneq_nxt;
  logic [1:0] tmode_r, tmode_nxt;
  logic signed [31:0] sref_r, sref_nxt;
  logic [7:0] act_r, act_nxt;
  logic [15:0] retry_r, retry_nxt;
  seq_t seq_r, seq_nxt;
  mds_in_t it_r;
  logic [15:0] bel16_r, bel16_nxt;

  logic div_start, div_done, div_busy;
  logic [16:0] div_q;

  mds_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(bel16_r),
    .den(blend_ms_r), .busy(div_busy), .done(div_done), .quo(div_q)
  );

  logic [31:0] el, bel, hel;
  logic [33:0] tmo;
  logic [16:0] bv;

  always_comb begin
    mode_nxt = mode_r; entry_nxt = entry_r; bstart_nxt = bstart_r;
    hstart_nxt = hstart_r; blend_nxt = blend_r; hstarted_nxt = hstarted_r;
    runq_nxt = runq_r; idq_nxt = idq_r; tuneq_nxt = tuneq_r; tmode_nxt = tmode_r;
    sref_nxt = sref_r; act_nxt = act_r; retry_nxt = retry_r; seq_nxt = seq_r;
    bel16_nxt = bel16_r; div_start = 1'b0;
    el = it_r.now_ms - entry_r;
    bel = it_r.now_ms - bstart_r;
    hel = it_r.now_ms - hstart_r;
    tmo = ({18'd0, hold_ms_r} + {18'd0, blend_ms_r}) * 34'd3;
    bv = blend_r;
    unique case (seq_r)
      SEQ_IDLE: if (in_valid) seq_nxt = SEQ_DIV;
      SEQ_DIV: begin
        seq_nxt = SEQ_OUT;
        unique case (it_r.action)
          ACT_LATCH: if (mode_r == ST_IDLE) begin
            if (it_r.command_op == OP_RUN_SPEED || it_r.command_op == OP_RUN_TORQUE) begin
              runq_nxt = 1'b1; sref_nxt = it_r.command_value;
            end else if (it_r.command_op == OP_IDENTIFY) idq_nxt = 1'b1;
            else if (it_r.command_op == OP_TUNE) begin
              tuneq_nxt = 1'b1; tmode_nxt = it_r.tune_request_mode;
            end
          end
          ACT_FAST: begin
            if (it_r.fault_bits[3:0] != 4'd0 && mode_r != ST_FAULT) begin
              mode_nxt = ST_FAULT; act_nxt = entry_actions(ST_FAULT);
            end else if (mode_r == ST_TRANS && blend_r >= Q16_ONE)
              act_nxt = act_r & 8'hFD;
          end
          ACT_TICK: begin
            if (mode_r == ST_TRANS && !(it_r.observer_confidence < mincf_r)
                && it_r.fault_bits == 16'd0 && bel < {16'd0, blend_ms_r}) begin
              bel16_nxt = bel[15:0];
              seq_nxt = SEQ_FIN;
            end else seq_nxt = SEQ_FIN;
          end
          default: ;
        endcase
      end
      SEQ_FIN: begin
        // slow tick evaluation; division runs first when needed
        if (mode_r == ST_TRANS && !(it_r.observer_confidence < mincf_r)
            && it_r.fault_bits == 16'd0 && bel < {16'd0, blend_ms_r}
            && !div_done) begin
          if (!div_busy) div_start = 1'b1;
        end else begin
          seq_nxt = SEQ_OUT;
          if (it_r.fault_bits != 16'd0 && mode_r != ST_FAULT && mode_r != ST_STOP
              && mode_r != ST_IDLE) begin
            mode_nxt = (it_r.fault_bits[6:4] != 3'd0) ? ST_STOP : ST_FAULT;
          end else begin
            unique case (mode_r)
              ST_IDLE: if (runq_r || idq_r || tuneq_r) mode_nxt = ST_INIT;
              ST_INIT: if (el >= INIT_WAIT_MS) mode_nxt = ST_CAL;
              ST_CAL: if (el >= CAL_WAIT_MS || it_r.phase_flags[0]) begin
                if (!it_r.phase_flags[1]) mode_nxt = ST_FAULT;
                else if (idq_r) mode_nxt = ST_IDENT;
                else if (runq_r || tuneq_r) mode_nxt = ST_ALIGN;
                else begin mode_nxt = ST_IDLE; runq_nxt = 1'b0; end
              end
              ST_IDENT: if (it_r.phase_flags[2] || el >= IDENT_WAIT_MS) begin
                if (!it_r.phase_flags[3]) mode_nxt = ST_FAULT;
                else begin idq_nxt = 1'b0; mode_nxt = runq_r ? ST_ALIGN : ST_IDLE; end
              end
              ST_ALIGN: if (el >= {16'd0, align_r}) begin
                runq_nxt = 1'b0;
                if (tuneq_r && tmode_r == 2'd0) begin
                  tuneq_nxt = 1'b0; mode_nxt = ST_TUNE;
                end else mode_nxt = ST_OLSTART;
              end
              ST_OLSTART: if (el >= 32'd1) mode_nxt = ST_OLRAMP;
              ST_OLRAMP: if (!(it_r.forced_speed < oltgt_r)) mode_nxt = ST_TRANS;
                         else if (el >= RAMP_TIMEOUT) mode_nxt = ST_STOP;
              ST_TRANS: begin
                if (it_r.observer_confidence < mincf_r) begin
                  if (retry_r != 16'hFFFF) retry_nxt = retry_r + 16'd1;
                  mode_nxt = ST_STOP;
                end else begin
                  bv = (bel >= {16'd0, blend_ms_r}) ? Q16_ONE : div_q;
                  if (!hstarted_r) hel = 32'd0;
                  if (hel >= {16'd0, hold_ms_r} && bv >= Q16_ONE) begin
                    if (tuneq_r && (tmode_r == 2'd1 || tmode_r == 2'd2)) begin
                      tuneq_nxt = 1'b0; mode_nxt = ST_TUNE;
                    end else mode_nxt = ST_RUN;
                  end
                  if ({2'd0, el} >= tmo) mode_nxt = ST_STOP;
                end
              end
              ST_RUN: if (it_r.command_op == OP_STOP) mode_nxt = ST_STOP;
              ST_TUNE: if (it_r.phase_flags[4] || it_r.command_op == OP_STOP)
                mode_nxt = ST_STOP;
              ST_STOP: if (el >= STOP_WAIT_MS) begin
                if (it_r.fault_bits != 16'd0) mode_nxt = ST_FAULT;
                else begin
                  mode_nxt = ST_IDLE; runq_nxt = 1'b0; idq_nxt = 1'b0; tuneq_nxt = 1'b0;
                end
              end
              ST_FAULT: if (it_r.command_op == OP_CLEAR) begin
                mode_nxt = ST_IDLE; runq_nxt = 1'b0; idq_nxt = 1'b0; tuneq_nxt = 1'b0;
              end else if (it_r.phase_flags[5] && it_r.fault_bits == 16'd0)
                mode_nxt = ST_INIT;
              default: ;
            endcase
          end
          if (mode_r == ST_TRANS && mode_nxt == ST_TRANS) begin
            blend_nxt = bv;
            if (!hstarted_r) begin hstart_nxt = it_r.now_ms; hstarted_nxt = 1'b1; end
          end
          // any transition taken on a slow tick re-enters the new state
          if (mode_nxt != mode_r) begin
            entry_nxt = it_r.now_ms; blend_nxt = 17'd0; hstarted_nxt = 1'b0;
            act_nxt = entry_actions(mode_nxt);
            if (mode_nxt == ST_TRANS) bstart_nxt = it_r.now_ms;
          end
        end
      end
      SEQ_OUT: if (!out_stall) seq_nxt = SEQ_IDLE;
      default: seq_nxt = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      align_r <= 16'd200; oltgt_r <= '0; mincf_r <= '0; hold_ms_r <= '0; blend_ms_r <= '0;
      mode_r <= ST_IDLE; entry_r <= '0; bstart_r <= '0; hstart_r <= '0; blend_r <= '0;
      hstarted_r <= 1'b0; runq_r <= 1'b0; idq_r <= 1'b0; tuneq_r <= 1'b0;
      tmode_r <= '0; sref_r <= '0; act_r <= '0; retry_r <= '0; seq_r <= SEQ_IDLE;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ALIGN: align_r <= cfg_data[15:0];
          CFG_OLTGT: oltgt_r <= cfg_data;
          CFG_MINCF: mincf_r <= cfg_data;
          CFG_HOLD:  hold_ms_r <= cfg_data[15:0];
          CFG_BLEND: blend_ms_r <= cfg_data[15:0];
          default: ;
        endcase
      end
      mode_r <= mode_nxt; entry_r <= entry_nxt; bstart_r <= bstart_nxt;
      hstart_r <= hstart_nxt; blend_r <= blend_nxt; hstarted_r <= hstarted_nxt;
      runq_r <= runq_nxt; idq_r <= idq_nxt; tuneq_r <= tuneq_nxt; tmode_r <= tmode_nxt;
      sref_r <= sref_nxt; act_r <= act_nxt; retry_r <= retry_nxt; seq_r <= seq_nxt;
    end
    bel16_r <= bel16_nxt;
    if (seq_r == SEQ_IDLE && in_valid) it_r <= in_data;
  end

  assign in_stall = (seq_r != SEQ_IDLE);
  assign out_valid = (seq_r == SEQ_OUT);
  assign out_data = '{current_state: mode_r, action_bits: act_r, blend_factor: blend_r,
                      transition_retries: retry_r, speed_reference: sref_r};
endmodule

### hdl/mds_checker.sv
`include "assert_macros.svh"
module mds_checker (
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input mds_pkg::mds_out_t out_data
);
  import mds_pkg::*;
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_data))
  `ASSERT_CLK(a_busy_out, clk, rst_n, out_valid |-> in_stall)
  `ASSERT_CLK(a_state_rng, clk, rst_n, out_valid |-> out_data.current_state <= 4'd11)
  `ASSERT_CLK(a_blend_rng, clk, rst_n, out_valid |-> out_data.blend_factor <= Q16_ONE)
  `ASSERT_RST(a_rst_idle, clk, !rst_n |=> !out_valid)
endmodule

bind motor_drive_supervisor_fsm mds_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

### tb/sv/motor_drive_supervisor_fsm_test.sv
module motor_drive_supervisor_fsm_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mds_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  mds_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  mds_out_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  motor_drive_supervisor_fsm dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // supervisor copy
  logic [15:0] sv_align, sv_hold, sv_blend;
  logic signed [31:0] sv_oltgt, sv_mincf;
  mode_t sv_mode;
  logic [31:0] sv_entry, sv_bstart, sv_hstart;
  logic [16:0] sv_bval;
  logic sv_hstarted, sv_run_req, sv_ident_req, sv_tune_req;
  logic [1:0] sv_tmode;
  logic signed [31:0] sv_sref;
  logic [7:0] sv_act;
  logic [15:0] sv_retries;

  mds_out_t status_queue[$];
  int errors = 0;
  int accepted_in = 0;

  // directed table: expected given only where obvious
  typedef struct {
    mds_in_t stim;
    bit known;
    mds_out_t status;
  } row_t;
  row_t dir_rows[$];

  function automatic void super_enter(mode_t s, logic [31:0] now);
    sv_mode = s;
    sv_entry = now;
    sv_bval = '0;
    sv_hstarted = 1'b0;
    case (s)
      ST_IDENT: sv_act = 8'h23;
      ST_ALIGN: sv_act = 8'h07;
      ST_OLSTART, ST_OLRAMP: sv_act = 8'h0F;
      ST_TRANS: sv_act = 8'h17;
      ST_RUN: sv_act = 8'h15;
      ST_TUNE: sv_act = 8'h55;
      ST_STOP: sv_act = 8'h15;
      ST_FAULT: sv_act = 8'h80;
      default: sv_act = 8'h00;
    endcase
    if (s == ST_TRANS) sv_bstart = now;
  endfunction

  function automatic void super_reset();
    sv_align = 16'd200; sv_hold = '0; sv_blend = '0;
    sv_oltgt = '0; sv_mincf = '0;
    sv_mode = ST_IDLE; sv_entry = '0; sv_bstart = '0; sv_hstart = '0;
    sv_bval = '0; sv_hstarted = 1'b0;
    sv_run_req = 1'b0; sv_ident_req = 1'b0; sv_tune_req = 1'b0;
    sv_tmode = '0; sv_sref = '0; sv_act = '0; sv_retries = '0;
  endfunction

  function automatic void super_tick(mds_in_t t);
    logic [31:0] el, bel;
    logic [63:0] q;
    logic [33:0] tmo;
    el = t.now_ms - sv_entry;
    if (t.fault_bits != 0 && sv_mode != ST_FAULT && sv_mode != ST_STOP
        && sv_mode != ST_IDLE) begin
      super_enter((t.fault_bits & 16'h0070) != 0 ? ST_STOP : ST_FAULT, t.now_ms);
      return;
    end
    case (sv_mode)
      ST_IDLE: if (sv_run_req || sv_ident_req || sv_tune_req) super_enter(ST_INIT, t.now_ms);
      ST_INIT: if (el >= INIT_WAIT_MS) super_enter(ST_CAL, t.now_ms);
      ST_CAL: if (el >= CAL_WAIT_MS || t.phase_flags[0]) begin
        if (!t.phase_flags[1]) super_enter(ST_FAULT, t.now_ms);
        else if (sv_ident_req) super_enter(ST_IDENT, t.now_ms);
        else if (sv_run_req || sv_tune_req) super_enter(ST_ALIGN, t.now_ms);
        else begin
          super_enter(ST_IDLE, t.now_ms);
          sv_run_req = 1'b0;
        end
      end
      ST_IDENT: if (t.phase_flags[2] || el >= IDENT_WAIT_MS) begin
        if (!t.phase_flags[3]) super_enter(ST_FAULT, t.now_ms);
        else begin
          sv_ident_req = 1'b0;
          super_enter(sv_run_req ? ST_ALIGN : ST_IDLE, t.now_ms);
        end
      end
      ST_ALIGN: if (el >= {16'd0, sv_align}) begin
        sv_run_req = 1'b0;
        if (sv_tune_req && sv_tmode == 2'd0) begin
          sv_tune_req = 1'b0;
          super_enter(ST_TUNE, t.now_ms);
        end else super_enter(ST_OLSTART, t.now_ms);
      end
      ST_OLSTART: if (el >= 1) super_enter(ST_OLRAMP, t.now_ms);
      ST_OLRAMP: begin
        if (!(t.forced_speed < sv_oltgt)) super_enter(ST_TRANS, t.now_ms);
        else if (el >= RAMP_TIMEOUT) super_enter(ST_STOP, t.now_ms);
      end
      ST_TRANS: begin
        if (t.observer_confidence < sv_mincf) begin
          if (sv_retries != 16'hFFFF) sv_retries++;
          super_enter(ST_STOP, t.now_ms);
        end else begin
          bel = t.now_ms - sv_bstart;
          if (bel >= {16'd0, sv_blend}) sv_bval = Q16_ONE;
          else begin
            q = ({32'd0, bel} << 16) / sv_blend;
            sv_bval = q[16:0];
          end
          if (!sv_hstarted) begin
            sv_hstart = t.now_ms;
            sv_hstarted = 1'b1;
          end
          if ((t.now_ms - sv_hstart) >= {16'd0, sv_hold} && sv_bval >= Q16_ONE) begin
            if (sv_tune_req && (sv_tmode == 2'd1 || sv_tmode == 2'd2)) begin
              sv_tune_req = 1'b0;
              super_enter(ST_TUNE, t.now_ms);
            end else super_enter(ST_RUN, t.now_ms);
          end
          tmo = ({18'd0, sv_hold} + {18'd0, sv_blend}) * 3;
          if ({2'd0, el} >= tmo) super_enter(ST_STOP, t.now_ms);
        end
      end
      ST_RUN: if (t.command_op == OP_STOP) super_enter(ST_STOP, t.now_ms);
      ST_TUNE: if (t.phase_flags[4] || t.command_op == OP_STOP) super_enter(ST_STOP, t.now_ms);
      ST_STOP: if (el >= STOP_WAIT_MS) begin
        if (t.fault_bits != 0) super_enter(ST_FAULT, t.now_ms);
        else begin
          super_enter(ST_IDLE, t.now_ms);
          sv_run_req = 1'b0; sv_ident_req = 1'b0; sv_tune_req = 1'b0;
        end
      end
      ST_FAULT: begin
        if (t.command_op == OP_CLEAR) begin
          super_enter(ST_IDLE, t.now_ms);
          sv_run_req = 1'b0; sv_ident_req = 1'b0; sv_tune_req = 1'b0;
        end else if (t.phase_flags[5] && t.fault_bits == 0) super_enter(ST_INIT, t.now_ms);
      end
      default: ;
    endcase
  endfunction

  function automatic mds_out_t super_step(mds_in_t t);
    mds_out_t r;
    if (t.action == ACT_LATCH) begin
      if (sv_mode == ST_IDLE) begin
        if (t.command_op == OP_RUN_SPEED || t.command_op == OP_RUN_TORQUE) begin
          sv_run_req = 1'b1;
          sv_sref = t.command_value;
        end else if (t.command_op == OP_IDENTIFY) sv_ident_req = 1'b1;
        else if (t.command_op == OP_TUNE) begin
          sv_tune_req = 1'b1;
          sv_tmode = t.tune_request_mode;
        end
      end
    end else if (t.action == ACT_FAST) begin
      if (t.fault_bits[3:0] != 0 && sv_mode != ST_FAULT) begin
        sv_mode = ST_FAULT;
        sv_act = 8'h80;
      end
      if (sv_mode == ST_TRANS && sv_bval >= Q16_ONE) sv_act[1] = 1'b0;
    end else if (t.action == ACT_TICK) super_tick(t);
    r.current_state = sv_mode;
    r.action_bits = sv_act;
    r.blend_factor = sv_bval;
    r.transition_retries = sv_retries;
    r.speed_reference = sv_sref;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic int short_gap();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) :
           ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 3));
  endfunction

  // result side
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (status_queue.size() == 0) begin
        $display("unexpected transaction at %0t", $realtime);
        errors++;
      end else begin
        mds_out_t w;
        w = status_queue.pop_front();
        if (out_data.current_state != w.current_state)
          report_mismatch("state", out_data.current_state, w.current_state);
        if (out_data.action_bits != w.action_bits)
          report_mismatch("action_bits", out_data.action_bits, w.action_bits);
        if (out_data.blend_factor != w.blend_factor)
          report_mismatch("blend", out_data.blend_factor, w.blend_factor);
        if (out_data.transition_retries != w.transition_retries)
          report_mismatch("retries", out_data.transition_retries, w.transition_retries);
        if (out_data.speed_reference != w.speed_reference)
          report_mismatch("speed", out_data.speed_reference, w.speed_reference);
      end
    end
  end

  int stall_left = 0;
  bit stall_quiet = 0;
  always @(posedge clk) begin
    if (stall_quiet) out_stall <= 1'b0;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left <= short_gap();
      out_stall <= 1'b1;
    end else out_stall <= 1'b0;
  end

  task automatic send(mds_in_t t, bit known, mds_out_t want);
    mds_out_t p;
    @(posedge clk);
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (in_stall);
    p = super_step(t);
    if (known && p != want) begin
      $display("directed row disagrees with predictor at %0t", $realtime);
      errors++;
    end
    status_queue.push_back(known ? want : p);
    accepted_in++;
    in_valid <= 1'b0;
  endtask

  task automatic send_gap(mds_in_t t);
    int g;
    send(t, 1'b0, '0);
    g = short_gap();
    repeat (g) @(posedge clk);
  endtask

  task automatic drain();
    while (status_queue.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ALIGN: sv_align = v[15:0];
      CFG_OLTGT: sv_oltgt = v;
      CFG_MINCF: sv_mincf = v;
      CFG_HOLD: sv_hold = v[15:0];
      CFG_BLEND: sv_blend = v[15:0];
      default: ;
    endcase
  endtask

  function automatic mds_in_t make_item(logic [1:0] a, logic [2:0] op, logic [31:0] now);
    mds_in_t t;
    t = '0;
    t.action = a;
    t.command_op = op;
    t.now_ms = now;
    t.phase_flags = 6'b001011;
    t.command_value = $urandom;
    t.forced_speed = 32'sh7FFFFFFF;
    t.observer_confidence = 32'sh7FFFFFFF;
    return t;
  endfunction

  function automatic mds_out_t status_of(mode_t s, logic [7:0] a, logic signed [31:0] r);
    mds_out_t o;
    o.current_state = s;
    o.action_bits = a;
    o.blend_factor = '0;
    o.transition_retries = '0;
    o.speed_reference = r;
    return o;
  endfunction

  function automatic void add_row(mds_in_t t, bit k, mds_out_t w);
    row_t r;
    r.stim = t; r.known = k; r.status = w;
    dir_rows.push_back(r);
  endfunction

  // one well-formed run with random content
  task automatic run_sequence(ref logic [31:0] clock_ms);
    mds_in_t t;
    int n;
    t = make_item(ACT_LATCH, 3'($urandom_range(1, 4)), clock_ms);
    t.tune_request_mode = $urandom;
    send_gap(t);
    if ($urandom_range(0, 2) == 0) begin
      t.command_op = 3'($urandom_range(1, 4));
      t.tune_request_mode = $urandom;
      send_gap(t);
    end
    n = $urandom_range(8, 25);
    repeat (n) begin
      clock_ms += ($urandom_range(0, 3) == 0) ? $urandom_range(0, 800) : $urandom_range(0, 30);
      t = make_item(ACT_TICK, 3'd0, clock_ms);
      t.action = ($urandom_range(0, 9) == 0) ? ACT_FAST : ACT_TICK;
      t.phase_flags = $urandom_range(0, 4) == 0 ? 6'($urandom) : 6'b011111;
      t.fault_bits = $urandom_range(0, 15) == 0 ? 16'(1 << $urandom_range(0, 15)) : 16'd0;
      t.forced_speed = $urandom_range(0, 1) ? 32'($urandom) : sv_oltgt;
      t.observer_confidence = $urandom_range(0, 5) == 0 ? 32'($urandom) : 32'sh7FFFFFFF;
      t.command_op = $urandom_range(0, 9) == 0 ? OP_STOP : 3'($urandom_range(0, 5));
      if ($urandom_range(0, 11) == 0) t.action = 2'd3;
      if ($urandom_range(0, 19) == 0) t.now_ms = $urandom;
      send_gap(t);
    end
    // return toward idle
    repeat (4) begin
      clock_ms += 600;
      t = make_item(ACT_TICK, OP_CLEAR, clock_ms);
      t.phase_flags = 6'b010000;
      send_gap(t);
    end
  endtask

  initial begin
    logic [31:0] clock_ms;
    mds_in_t t;
    super_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    t = make_item(2'd3, 3'd0, 32'd0);
    add_row(t, 1'b1, status_of(ST_IDLE, 8'h00, 32'sd0));
    t = make_item(ACT_LATCH, OP_RUN_SPEED, 32'd0);
    t.command_value = 32'sh80000000;
    add_row(t, 1'b1, status_of(ST_IDLE, 8'h00, 32'sh80000000));
    t = make_item(ACT_LATCH, OP_RUN_TORQUE, 32'd0);
    t.command_value = 32'sh7FFFFFFF;
    add_row(t, 1'b1, status_of(ST_IDLE, 8'h00, 32'sh7FFFFFFF));
    t = make_item(ACT_LATCH, 3'd7, 32'd0);
    t.command_value = 32'sd5;
    add_row(t, 1'b1, status_of(ST_IDLE, 8'h00, 32'sh7FFFFFFF));
    t = make_item(ACT_LATCH, OP_TUNE, 32'd0);
    t.tune_request_mode = 2'd3;
    add_row(t, 1'b0, '0);
    t = make_item(ACT_LATCH, OP_IDENTIFY, 32'd0);
    add_row(t, 1'b0, '0);
    t = make_item(ACT_TICK, 3'd0, 32'hFFFFFF00);
    add_row(t, 1'b1, status_of(ST_INIT, 8'h00, 32'sh7FFFFFFF));
    t = make_item(ACT_TICK, 3'd0, 32'd100);
    add_row(t, 1'b1, status_of(ST_CAL, 8'h00, 32'sh7FFFFFFF));
    t = make_item(ACT_TICK, 3'd0, 32'd101);
    t.phase_flags = 6'h3F;
    add_row(t, 1'b1, status_of(ST_IDENT, 8'h23, 32'sh7FFFFFFF));
    t = make_item(ACT_TICK, 3'd0, 32'd102);
    t.phase_flags = 6'h3F;
    add_row(t, 1'b1, status_of(ST_ALIGN, 8'h07, 32'sh7FFFFFFF));
    t = make_item(ACT_TICK, 3'd0, 32'd102);
    add_row(t, 1'b0, '0);
    t = make_item(ACT_TICK, 3'd0, 32'd302);
    add_row(t, 1'b1, status_of(ST_OLSTART, 8'h0F, 32'sh7FFFFFFF));
    t = make_item(ACT_TICK, 3'd0, 32'd303);
    add_row(t, 1'b1, status_of(ST_OLRAMP, 8'h0F, 32'sh7FFFFFFF));
    t = make_item(ACT_TICK, 3'd0, 32'd304);
    add_row(t, 1'b0, '0);
    t = make_item(ACT_FAST, 3'd0, 32'd304);
    add_row(t, 1'b0, '0);
    t = make_item(ACT_TICK, 3'd0, 32'd305);
    add_row(t, 1'b0, '0);
    t = make_item(ACT_TICK, OP_STOP, 32'd306);
    add_row(t, 1'b0, '0);
    t = make_item(ACT_FAST, 3'd0, 32'd306);
    t.fault_bits = 16'hFFFF;
    add_row(t, 1'b1, status_of(ST_FAULT, 8'h80, 32'sh7FFFFFFF));
    t = make_item(ACT_TICK, 3'd0, 32'd307);
    t.fault_bits = 16'h8000;
    t.phase_flags = 6'h20;
    add_row(t, 1'b0, '0);
    t = make_item(ACT_TICK, OP_CLEAR, 32'd308);
    add_row(t, 1'b1, status_of(ST_IDLE, 8'h00, 32'sh7FFFFFFF));

    write_reg(CFG_ALIGN, 32'd200);
    write_reg(CFG_OLTGT, 32'h80000000);
    write_reg(CFG_MINCF, 32'h80000000);
    write_reg(CFG_HOLD, 32'd0);
    write_reg(CFG_BLEND, 32'd0);
    foreach (dir_rows[i]) send(dir_rows[i].stim, dir_rows[i].known, dir_rows[i].status);
    drain();

    // random phases with several settings
    clock_ms = $urandom;
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      stall_quiet = (ph == 3);
      write_reg(CFG_ALIGN, ph == 1 ? 32'd65535 : 32'($urandom_range(0, 300)));
      write_reg(CFG_OLTGT, ph == 2 ? 32'h7FFFFFFF : 32'($urandom));
      write_reg(CFG_MINCF, ph == 2 ? 32'h7FFFFFFF : (ph % 2 ? 32'h80000000 : 32'($urandom)));
      write_reg(CFG_HOLD, ph == 4 ? 32'd65535 : 32'($urandom_range(0, 60)));
      write_reg(CFG_BLEND, ph == 5 ? 32'd65535 : (ph == 6 ? 32'd0 : 32'($urandom_range(1, 80))));
      while (accepted_in < 60 + (ph + 1) * 230) begin
        if ($urandom_range(0, 5) == 0) begin
          t = make_item(2'($urandom_range(0, 3)), 3'($urandom), $urandom);
          t.command_value = $urandom;
          t.tune_request_mode = $urandom;
          t.fault_bits = $urandom;
          t.phase_flags = $urandom;
          t.forced_speed = $urandom;
          t.observer_confidence = $urandom;
          send_gap(t);
        end else run_sequence(clock_ms);
        if (accepted_in % 97 == 0) drain();
      end
    end
    drain();
    if (errors == 0 && status_queue.size() == 0) begin
      $display("motor_drive_supervisor_fsm test passed");
    end else begin
      $display("motor_drive_supervisor_fsm test failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("motor_drive_supervisor_fsm test failed");
    $finish;
  end
endmodule
